[rtl/wab_pkg.sv]
// ----------------------------------------------------------------------------
// wab_pkg
// Types and constants shared by the watermark alpha-blend block.
// ----------------------------------------------------------------------------
`default_nettype none

package wab_pkg;

  typedef struct packed {
    logic        cmd;
    logic [15:0] mark_addr;
    logic [7:0]  sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result;
    logic       marked;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [16:0] weight;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [7:0]  mark_width;
    logic [7:0]  mark_height;
    logic [2:0]  image_bands;
    logic [2:0]  mark_bands;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_MODE, REG_WEIGHT, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT,
    REG_MARK_WIDTH, REG_MARK_HEIGHT, REG_IMAGE_BANDS, REG_MARK_BANDS
  } reg_idx_t;

  // Classified request between the front and back ends.
  typedef struct packed {
    logic        is_load;
    logic [15:0] mark_addr;
    logic [7:0]  sample;
    logic        hit;
    logic [6:0]  lx;
    logic [6:0]  ly;
    logic [2:0]  wb;
    logic        frame_end;
  } q_entry_t;

  typedef struct packed {
    logic busy;
    logic push;
  } front_status_t;

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_LOAD, SEQ_STEP, SEQ_SAVE} seq_state_t;

  localparam int         MAX_DIM      = 4096;
  localparam int         MAX_BANDS    = 4;
  localparam logic       CMD_LOAD     = 1'b0;
  localparam logic [3:0] MODE_LAST_FIX = 4'd6;
  localparam logic [3:0] MODE_DENSE   = 4'd7;
  localparam logic [3:0] MODE_SPARSE  = 4'd8;
  localparam logic [1:0] SEL_START    = 2'd0;
  localparam logic [1:0] SEL_CENTER   = 2'd1;
  localparam logic [1:0] SEL_END      = 2'd2;
  localparam logic [16:0] ONE_Q16     = 17'h10000;
  localparam logic [7:0] SAMPLE_MAX   = 8'hFF;
  localparam logic [7:0] MARK_MAX_DIM = 8'd128;
  localparam int TIX_W   = 12;
  localparam int DIV_W   = 13;
  localparam logic [3:0] DIV_LAST = 4'd12;
  localparam logic [1:0] OP_LAST  = 2'd3;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  function automatic logic [1:0] x_sel(input logic [3:0] mode);
    unique case (mode)
      4'd1, 4'd3, 4'd5: x_sel = SEL_CENTER;
      4'd2, 4'd6:       x_sel = SEL_END;
      default:          x_sel = SEL_START;
    endcase
  endfunction

  function automatic logic [1:0] y_sel(input logic [3:0] mode);
    unique case (mode)
      4'd3:             y_sel = SEL_CENTER;
      4'd4, 4'd5, 4'd6: y_sel = SEL_END;
      default:          y_sel = SEL_START;
    endcase
  endfunction

endpackage

`default_nettype wire

[rtl/wab_ram.sv]
// ----------------------------------------------------------------------------
// wab_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/wab_fifo.sv]
// ----------------------------------------------------------------------------
// wab_fifo
// Short request queue between the classifying front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wab_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wab_pkg::q_entry_t      din,
  output logic                   full,
  input  wire logic              pop,
  output wab_pkg::q_entry_t      dout,
  output logic                   empty
);
  import wab_pkg::*;

  q_entry_t             slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [Q_PTR_W:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = slot_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= din;
    end
  end

endmodule

`default_nettype wire

[rtl/wab_front.sv]
// ----------------------------------------------------------------------------
// wab_front
// Accepts requests, tracks band/column/row/tile position, decides coverage,
// and derives the sparse tile counts with a bit-serial divider after setup.
// ----------------------------------------------------------------------------
`default_nettype none

module wab_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wab_pkg::cfg_t             cfg,
  input  wire logic                 cfg_wr,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wab_pkg::in_item_t         in_data,
  input  wire logic                 q_full,
  output wab_pkg::q_entry_t         q_din,
  output wab_pkg::front_status_t    status
);
  import wab_pkg::*;

  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int CMP_W  = (CNT_W + 1 > 14) ? CNT_W + 1 : 14;
  localparam int BAND_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int BC_W   = (BAND_W + 1 > 3) ? BAND_W + 1 : 3;

  // position counters
  logic [BAND_W-1:0] band_r, band_nxt, wb_r, wb_nxt;
  logic [CNT_W-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic [7:0]        tlx_r, tlx_nxt, tly_r, tly_nxt;
  logic [TIX_W-1:0]  tix_r, tix_nxt, tiy_r, tiy_nxt;
  logic              frame_end;

  // placement registers, refreshed every cycle from the configuration; tile counts in wide_r/high_r
  logic [12:0] ox_r, oy_r;
  logic [13:0] oxe_r, oye_r;
  logic [7:0]  px_r, py_r;
  logic [13:0] wide_r, high_r;

  // tile-count divider
  seq_state_t      state_r, state_nxt;
  logic [1:0]      op_r;
  logic [3:0]      step_r;
  logic [DIV_W-1:0] dvd_r, quo_r;
  logic [8:0]      rem_r;
  logic            busy, do_load, do_step, do_save;
  logic [DIV_W-1:0] dividend;
  logic [7:0]      divisor;
  logic [8:0]      trial;
  logic            qbit;

  logic accept, pixel, hit, cov;
  logic [6:0] lx, ly;

  // ---------------- divider sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE: state_nxt = SEQ_IDLE;
      SEQ_LOAD: state_nxt = SEQ_STEP;
      SEQ_STEP: state_nxt = (step_r == DIV_LAST) ? SEQ_SAVE : SEQ_STEP;
      SEQ_SAVE: state_nxt = (op_r == OP_LAST) ? SEQ_IDLE : SEQ_LOAD;
      default:  state_nxt = SEQ_IDLE;
    endcase
    if (cfg_wr) begin
      state_nxt = SEQ_LOAD;
    end
  end

  always_comb begin
    busy    = (state_r != SEQ_IDLE);
    do_load = (state_r == SEQ_LOAD);
    do_step = (state_r == SEQ_STEP);
    do_save = (state_r == SEQ_SAVE);
  end

  always_comb begin
    dividend = op_r[1] ? cfg.image_height : cfg.image_width;
    unique case (op_r)
      2'd0:    divisor = cfg.mark_width + (cfg.mark_width >> 1);
      2'd1:    divisor = cfg.mark_width;
      2'd2:    divisor = cfg.mark_height + (cfg.mark_height >> 1);
      default: divisor = cfg.mark_height;
    endcase
    trial = {rem_r[7:0], dvd_r[DIV_W-1]};
    qbit  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_LOAD;
      op_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        op_r <= '0;
      end else if (do_save) begin
        op_r <= op_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      dvd_r  <= dividend;
      rem_r  <= '0;
      quo_r  <= '0;
      step_r <= '0;
    end
    if (do_step) begin
      rem_r  <= qbit ? trial - {1'b0, divisor} : trial;
      dvd_r  <= dvd_r << 1;
      quo_r  <= {quo_r[DIV_W-2:0], qbit};
      step_r <= step_r + 1'b1;
    end
    if (do_save) begin
      unique case (op_r)
        2'd0:    wide_r <= 14'(quo_r);
        2'd1:    wide_r <= wide_r + 14'(rem_r != '0);
        2'd2:    high_r <= 14'(quo_r);
        default: high_r <= high_r + 14'(rem_r != '0);
      endcase
    end
  end

  // ---------------- placement ----------------
  always_ff @(posedge clk) begin
    logic [12:0] ox, oy;
    ox = '0;
    oy = '0;
    if (cfg.image_width > 13'(cfg.mark_width)) begin
      unique case (x_sel(cfg.mode))
        SEL_CENTER: ox = (cfg.image_width - 13'(cfg.mark_width)) >> 1;
        SEL_END:    ox = cfg.image_width - 13'(cfg.mark_width);
        default:    ox = '0;
      endcase
    end
    if (cfg.image_height > 13'(cfg.mark_height)) begin
      unique case (y_sel(cfg.mode))
        SEL_CENTER: oy = (cfg.image_height - 13'(cfg.mark_height)) >> 1;
        SEL_END:    oy = cfg.image_height - 13'(cfg.mark_height);
        default:    oy = '0;
      endcase
    end
    ox_r  <= ox;
    oy_r  <= oy;
    oxe_r <= 14'(ox) + 14'(cfg.mark_width);
    oye_r <= 14'(oy) + 14'(cfg.mark_height);
    px_r  <= (cfg.mode == MODE_SPARSE) ? cfg.mark_width + (cfg.mark_width >> 1)
                                       : cfg.mark_width;
    py_r  <= (cfg.mode == MODE_SPARSE) ? cfg.mark_height + (cfg.mark_height >> 1)
                                       : cfg.mark_height;
  end

  // ---------------- coverage ----------------
  always_comb begin
    cov = 1'b0;
    lx  = '0;
    ly  = '0;
    if (cfg.mode <= MODE_LAST_FIX) begin
      cov = (CMP_W'(col_r) >= CMP_W'(ox_r)) && (CMP_W'(col_r) < CMP_W'(oxe_r)) &&
            (CMP_W'(row_r) >= CMP_W'(oy_r)) && (CMP_W'(row_r) < CMP_W'(oye_r));
      lx  = 7'(CMP_W'(col_r) - CMP_W'(ox_r));
      ly  = 7'(CMP_W'(row_r) - CMP_W'(oy_r));
    end else if (cfg.mode == MODE_DENSE || cfg.mode == MODE_SPARSE) begin
      cov = (tlx_r < cfg.mark_width) && (tly_r < cfg.mark_height);
      if (cfg.mode == MODE_SPARSE) begin
        cov = cov && (14'(tix_r) < wide_r) && (14'(tiy_r) < high_r);
      end
      lx = 7'(tlx_r);
      ly = 7'(tly_r);
    end
    hit = cov && (cfg.weight != '0);
  end

  // ---------------- counter advance ----------------
  always_comb begin
    logic [BC_W-1:0]  bc_inc, wb_inc;
    logic [CMP_W-1:0] col_inc, row_inc;
    logic [8:0]       tlx_inc, tly_inc;
    bc_inc  = BC_W'(band_r) + 1'b1;
    wb_inc  = BC_W'(wb_r) + 1'b1;
    col_inc = CMP_W'(col_r) + 1'b1;
    row_inc = CMP_W'(row_r) + 1'b1;
    tlx_inc = 9'(tlx_r) + 1'b1;
    tly_inc = 9'(tly_r) + 1'b1;
    band_nxt  = band_r;
    wb_nxt    = wb_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    tlx_nxt   = tlx_r;
    tly_nxt   = tly_r;
    tix_nxt   = tix_r;
    tiy_nxt   = tiy_r;
    frame_end = 1'b0;
    if (bc_inc < BC_W'(cfg.image_bands)) begin
      band_nxt = BAND_W'(bc_inc);
      wb_nxt   = (wb_inc >= BC_W'(cfg.mark_bands)) ? '0 : BAND_W'(wb_inc);
    end else begin
      band_nxt = '0;
      wb_nxt   = '0;
      if (tlx_inc >= 9'(px_r)) begin
        tlx_nxt = '0;
        tix_nxt = tix_r + 1'b1;
      end else begin
        tlx_nxt = 8'(tlx_inc);
      end
      if (col_inc < CMP_W'(cfg.image_width)) begin
        col_nxt = CNT_W'(col_inc);
      end else begin
        col_nxt = '0;
        tlx_nxt = '0;
        tix_nxt = '0;
        if (tly_inc >= 9'(py_r)) begin
          tly_nxt = '0;
          tiy_nxt = tiy_r + 1'b1;
        end else begin
          tly_nxt = 8'(tly_inc);
        end
        if (row_inc < CMP_W'(cfg.image_height)) begin
          row_nxt = CNT_W'(row_inc);
        end else begin
          row_nxt   = '0;
          tly_nxt   = '0;
          tiy_nxt   = '0;
          frame_end = 1'b1;
        end
      end
    end
  end

  assign in_ready = !busy && !q_full;
  assign accept   = in_valid && in_ready;
  assign pixel    = (in_data.cmd != CMD_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r <= '0;
      wb_r   <= '0;
      col_r  <= '0;
      row_r  <= '0;
      tlx_r  <= '0;
      tly_r  <= '0;
      tix_r  <= '0;
      tiy_r  <= '0;
    end else if (accept && pixel) begin
      band_r <= band_nxt;
      wb_r   <= wb_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      tlx_r  <= tlx_nxt;
      tly_r  <= tly_nxt;
      tix_r  <= tix_nxt;
      tiy_r  <= tiy_nxt;
    end else if (cfg_wr) begin
      // re-derive the watermark band from the band counter
      wb_r <= band_r;
    end else if (busy && BC_W'(wb_r) >= BC_W'(cfg.mark_bands)) begin
      wb_r <= BAND_W'(BC_W'(wb_r) - BC_W'(cfg.mark_bands));
    end
  end

  always_comb begin
    q_din.is_load   = !pixel;
    q_din.mark_addr = in_data.mark_addr;
    q_din.sample    = in_data.sample;
    q_din.hit       = hit;
    q_din.lx        = lx;
    q_din.ly        = ly;
    q_din.wb        = 3'(wb_r);
    q_din.frame_end = frame_end;
    status.busy     = busy;
    status.push     = accept;
  end

endmodule

`default_nettype wire

[rtl/wab_back.sv]
// ----------------------------------------------------------------------------
// wab_back
// Executes queued requests: store writes, watermark reads and the blend.
// Stages: store read, products, sum and saturate into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wab_back #(
  parameter int MARK_STORE_DEPTH = 65536
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wab_pkg::cfg_t          cfg,
  input  wire logic              q_empty,
  input  wab_pkg::q_entry_t      q_dout,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output wab_pkg::out_item_t     out_data
);
  import wab_pkg::*;

  localparam int AW = $clog2(MARK_STORE_DEPTH);

  logic [14:0] plane_r;
  logic [17:0] raddr_full;
  logic [AW-1:0] raddr, waddr;
  logic [7:0]  wm;
  logic        re, we;

  logic        s1_valid_r, s1_hit_r, s1_fe_r;
  logic [7:0]  s1_smp_r;
  logic        s2_valid_r, s2_mark_r, s2_fe_r;
  logic [7:0]  s2_smp_r;
  logic [24:0] s2_pin_r, s2_pwm_r;
  logic        out_valid_r;
  out_item_t   out_data_r;
  logic        out_en, s2_en, s1_en;
  logic [25:0] sum;
  logic [7:0]  blended;

  always_ff @(posedge clk) begin
    plane_r <= 15'(cfg.mark_width) * 15'(cfg.mark_height);
  end

  assign out_en = !out_valid_r || out_ready;
  assign s2_en  = !s2_valid_r || out_en;
  assign s1_en  = !s1_valid_r || s2_en;
  assign q_pop  = !q_empty && s1_en;

  assign raddr_full = 18'(q_dout.wb) * 18'(plane_r) +
                      18'(q_dout.ly) * 18'(cfg.mark_width) + 18'(q_dout.lx);
  assign raddr = AW'(raddr_full);
  assign waddr = AW'(q_dout.mark_addr);
  assign we    = q_pop && q_dout.is_load;
  assign re    = q_pop && !q_dout.is_load;

  wab_ram #(.WIDTH(8), .DEPTH(MARK_STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (q_dout.sample),
    .re    (re),
    .raddr (raddr),
    .rdata (wm)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_r <= re;
      end
      if (s2_en) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_en) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && re) begin
      s1_hit_r <= q_dout.hit;
      s1_smp_r <= q_dout.sample;
      s1_fe_r  <= q_dout.frame_end;
    end
    if (s2_en && s1_valid_r) begin
      s2_mark_r <= s1_hit_r && (wm != '0);
      s2_smp_r  <= s1_smp_r;
      s2_fe_r   <= s1_fe_r;
      s2_pin_r  <= 25'(s1_smp_r) * 25'(ONE_Q16 - cfg.weight);
      s2_pwm_r  <= 25'(wm) * 25'(cfg.weight);
    end
    if (out_en && s2_valid_r) begin
      out_data_r.result    <= s2_mark_r ? blended : s2_smp_r;
      out_data_r.marked    <= s2_mark_r;
      out_data_r.frame_end <= s2_fe_r;
    end
  end

  // a null input contributes nothing, so its product is already zero
  always_comb begin
    sum = 26'(s2_pin_r) + 26'(s2_pwm_r);
    if (sum < 26'(ONE_Q16)) begin
      blended = '0;
    end else if (sum >= {2'b0, SAMPLE_MAX, 16'h0}) begin
      blended = SAMPLE_MAX;
    end else begin
      blended = sum[23:16];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/watermark_alpha_blend.sv]
// ----------------------------------------------------------------------------
// watermark_alpha_blend
// Overlays a stored watermark on a band-interleaved raster sample stream.
//
//   channel  ports                          direction  moves
//   in       in_valid/in_ready/in_data      in         load or image request
//   out      out_valid/out_ready/out_data   out        one result per image sample
//   cfg      psel/penable/pwrite/paddr/...  in         register writes and reads
//
// One request per clock while the front is not busy and the queue has room; the queue
// entry is written at the accepting edge and an image sample reaches out_data through
// the store read, products and output register stages.
// After reset and after every register write the front runs a bit-serial
// divider for the sparse tile counts, and in_ready stays low until it is done.
// A stalled output backs up the stages and then the 4-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module watermark_alpha_blend #(
  parameter int MARK_STORE_DEPTH = 65536
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wab_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output wab_pkg::out_item_t       out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import wab_pkg::*;

  cfg_t          cfg_r;
  logic          cfg_wr;
  reg_idx_t      idx;
  front_status_t fst;
  q_entry_t      q_din, q_dout;
  logic          q_full, q_empty, q_pop;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    logic [12:0] d13;
    logic [7:0]  d8;
    logic [2:0]  d3;
    d13 = pwdata[12:0];
    d8  = pwdata[7:0];
    d3  = pwdata[2:0];
    if (!rst_n) begin
      cfg_r.mode         <= '0;
      cfg_r.weight       <= 17'd13107;
      cfg_r.image_width  <= 13'd1;
      cfg_r.image_height <= 13'd1;
      cfg_r.mark_width   <= 8'd1;
      cfg_r.mark_height  <= 8'd1;
      cfg_r.image_bands  <= 3'd1;
      cfg_r.mark_bands   <= 3'd1;
    end else if (cfg_wr) begin
      unique case (idx)
        REG_MODE:   cfg_r.mode <= pwdata[3:0];
        REG_WEIGHT: cfg_r.weight <= (pwdata[16:0] > ONE_Q16) ? ONE_Q16 : pwdata[16:0];
        REG_IMAGE_WIDTH:
          cfg_r.image_width <= (d13 == '0) ? 13'd1 :
                               (32'(d13) > MAX_DIM) ? 13'(MAX_DIM) : d13;
        REG_IMAGE_HEIGHT:
          cfg_r.image_height <= (d13 == '0) ? 13'd1 :
                                (32'(d13) > MAX_DIM) ? 13'(MAX_DIM) : d13;
        REG_MARK_WIDTH:
          cfg_r.mark_width <= (d8 == '0) ? 8'd1 : (d8 > MARK_MAX_DIM) ? MARK_MAX_DIM : d8;
        REG_MARK_HEIGHT:
          cfg_r.mark_height <= (d8 == '0) ? 8'd1 : (d8 > MARK_MAX_DIM) ? MARK_MAX_DIM : d8;
        REG_IMAGE_BANDS:
          cfg_r.image_bands <= (d3 == '0) ? 3'd1 :
                               (32'(d3) > MAX_BANDS) ? 3'(MAX_BANDS) : d3;
        REG_MARK_BANDS:
          cfg_r.mark_bands <= (d3 == '0) ? 3'd1 :
                              (32'(d3) > MAX_BANDS) ? 3'(MAX_BANDS) : d3;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:         prdata = 32'(cfg_r.mode);
      REG_WEIGHT:       prdata = 32'(cfg_r.weight);
      REG_IMAGE_WIDTH:  prdata = 32'(cfg_r.image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(cfg_r.image_height);
      REG_MARK_WIDTH:   prdata = 32'(cfg_r.mark_width);
      REG_MARK_HEIGHT:  prdata = 32'(cfg_r.mark_height);
      REG_IMAGE_BANDS:  prdata = 32'(cfg_r.image_bands);
      REG_MARK_BANDS:   prdata = 32'(cfg_r.mark_bands);
      default:          prdata = '0;
    endcase
  end

  wab_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cfg_wr   (cfg_wr),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_din    (q_din),
    .status   (fst)
  );

  wab_fifo u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fst.push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  wab_back #(.MARK_STORE_DEPTH(MARK_STORE_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_dout    (q_dout),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    fst.push |-> !q_full) else $error("request pushed into a full queue");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fst.busy |-> !(in_valid && in_ready)) else $error("request taken during tile count");

  a_marked_needs_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.marked) |-> (cfg_r.weight != '0))
    else $error("marked result with zero weight");

  a_busy_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> fst.busy) else $error("register write did not restart tile count");

endmodule

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Loads watermark stores and streams image samples through
// watermark_alpha_blend over many placement and register settings, then
// compares every result with a cycle-free prediction of the blend.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import wab_pkg::*;

  class blend_scoreboard;
    bit [7:0]    mark_mem [65536];
    int unsigned mode, weight, img_w, img_h, mk_w, mk_h, img_b, mk_b;
    int unsigned band_cnt, col, row, tlx, tly, tix, tiy;
    out_item_t   expected_q [$];
    int          errors;

    function new();
      mode = 0; weight = 13107; img_w = 1; img_h = 1;
      mk_w = 1; mk_h = 1; img_b = 1; mk_b = 1;
      band_cnt = 0; col = 0; row = 0; tlx = 0; tly = 0; tix = 0; tiy = 0;
      errors = 0;
    endfunction

    function int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(reg_idx_t idx, bit [31:0] v);
      case (idx)
        REG_MODE:         mode   = v[3:0];
        REG_WEIGHT:       weight = clip(v[16:0], 0, 65536);
        REG_IMAGE_WIDTH:  img_w  = clip(v[12:0], 1, 4096);
        REG_IMAGE_HEIGHT: img_h  = clip(v[12:0], 1, 4096);
        REG_MARK_WIDTH:   mk_w   = clip(v[7:0], 1, 128);
        REG_MARK_HEIGHT:  mk_h   = clip(v[7:0], 1, 128);
        REG_IMAGE_BANDS:  img_b  = clip(v[2:0], 1, 4);
        REG_MARK_BANDS:   mk_b   = clip(v[2:0], 1, 4);
        default: ;
      endcase
    endfunction

    // sel: 0 start, 1 center, 2 end
    function int unsigned origin(int unsigned sel, int unsigned img, int unsigned mk);
      if (img <= mk || sel == 0) return 0;
      return (sel == 1) ? (img - mk) / 2 : img - mk;
    endfunction

    function bit covers(output int unsigned lx, output int unsigned ly);
      int unsigned sx, sy, ox, oy, across, down;
      lx = 0; ly = 0;
      if (mode < 7) begin
        sx = (mode == 1 || mode == 3 || mode == 5) ? 1 : (mode == 2 || mode == 6) ? 2 : 0;
        sy = (mode == 3) ? 1 : (mode >= 4) ? 2 : 0;
        ox = origin(sx, img_w, mk_w);
        oy = origin(sy, img_h, mk_h);
        if (col < ox || col >= ox + mk_w || row < oy || row >= oy + mk_h) return 0;
        lx = col - ox;
        ly = row - oy;
        return 1;
      end
      if (mode == 7 || mode == 8) begin
        if (tlx >= mk_w || tly >= mk_h) return 0;
        if (mode == 8) begin
          across = img_w / (mk_w + mk_w / 2) + ((img_w % mk_w) != 0);
          down   = img_h / (mk_h + mk_h / 2) + ((img_h % mk_h) != 0);
          if (tix >= across || tiy >= down) return 0;
        end
        lx = tlx;
        ly = tly;
        return 1;
      end
      return 0;
    endfunction

    // advance raster position; report end of frame
    function bit step_position();
      int unsigned px, py;
      px = (mode == 8) ? mk_w + mk_w / 2 : mk_w;
      py = (mode == 8) ? mk_h + mk_h / 2 : mk_h;
      band_cnt++;
      if (band_cnt < img_b) return 0;
      band_cnt = 0;
      col++;
      tlx++;
      if (tlx >= px) begin
        tlx = 0;
        tix = (tix + 1) & 12'hFFF;
      end
      if (col < img_w) return 0;
      col = 0; tlx = 0; tix = 0;
      row++;
      tly++;
      if (tly >= py) begin
        tly = 0;
        tiy = (tiy + 1) & 12'hFFF;
      end
      if (row < img_h) return 0;
      row = 0; tly = 0; tiy = 0;
      return 1;
    endfunction

    function void note_request(in_item_t d);
      out_item_t       o;
      int unsigned     lx, ly, addr;
      bit [7:0]        wm;
      longint unsigned s;
      if (d.cmd == CMD_LOAD) begin
        mark_mem[d.mark_addr] = d.sample;
        return;
      end
      o.result = d.sample;
      o.marked = 1'b0;
      if (weight != 0 && covers(lx, ly)) begin
        addr = ((band_cnt % mk_b) * mk_w * mk_h + ly * mk_w + lx) % 65536;
        wm = mark_mem[addr];
        if (wm != 0) begin
          s = (d.sample != 0 ? longint'(d.sample) * (65536 - weight) : 0)
              + longint'(wm) * weight;
          if (s < 65536) o.result = 8'd0;
          else if (s >= (longint'(255) << 16)) o.result = 8'hFF;
          else o.result = 8'(s >> 16);
          o.marked = 1'b1;
        end
      end
      o.frame_end = step_position();
      expected_q.insert(expected_q.size(), o);
    endfunction

    function void check_result(out_item_t r);
      out_item_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result %0d", r.result);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (r.result !== e.result) begin
        $error("result: expected %0d, got %0d", e.result, r.result);
        errors++;
      end
      if (r.marked !== e.marked) begin
        $error("marked: expected %0d, got %0d", e.marked, r.marked);
        errors++;
      end
      if (r.frame_end !== e.frame_end) begin
        $error("frame_end: expected %0d, got %0d", e.frame_end, r.frame_end);
        errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  blend_scoreboard sb = new();
  int  burst_left = 0;
  int  hold_cnt = 0;
  int  ready_style = 0;
  bit  long_hold_req = 1'b0;
  int  idle_cycles = 0;
  int  sent_count = 0;

  watermark_alpha_blend u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // receiver stall pattern
  always @(posedge clk) begin
    if (long_hold_req) begin
      hold_cnt = 300;
      long_hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) ready_style = $urandom_range(0, 2);
      case (ready_style)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic push_request(in_item_t d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    sent_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    // hold for loads still in flight
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, bit [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bit [7:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // configure, fill the watermark, stream n image samples
  task automatic run_phase(bit [31:0] md, bit [31:0] wt, bit [31:0] iw, bit [31:0] ih,
                           bit [31:0] mw, bit [31:0] mh, bit [31:0] ib, bit [31:0] mb,
                           int n, bit long_hold);
    in_item_t    d;
    int unsigned span;
    wait_drained();
    write_reg(REG_MODE, md);
    write_reg(REG_WEIGHT, wt);
    write_reg(REG_IMAGE_WIDTH, iw);
    write_reg(REG_IMAGE_HEIGHT, ih);
    write_reg(REG_MARK_WIDTH, mw);
    write_reg(REG_MARK_HEIGHT, mh);
    write_reg(REG_IMAGE_BANDS, ib);
    write_reg(REG_MARK_BANDS, mb);
    span = sb.mk_b * sb.mk_w * sb.mk_h;
    for (int unsigned a = 0; a < span; a++) begin
      d.cmd = CMD_LOAD;
      d.mark_addr = 16'(a);
      d.sample = rand_sample();
      push_request(d);
    end
    if (long_hold) long_hold_req = 1'b1;
    for (int i = 0; i < n; i++) begin
      // drop in a stray load now and then
      if ($urandom_range(0, 15) == 0) begin
        d.cmd = CMD_LOAD;
        d.mark_addr = 16'($urandom_range(0, 65535));
        d.sample = rand_sample();
        push_request(d);
      end
      d.cmd = ~CMD_LOAD;
      d.mark_addr = 16'($urandom_range(0, 65535));
      d.sample = rand_sample();
      push_request(d);
    end
  endtask

  initial begin
    in_item_t d;
    int       w;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a few samples at reset settings
    for (int i = 0; i < 4; i++) begin
      d.cmd = CMD_LOAD; d.mark_addr = 16'hFFFF; d.sample = 8'hFF;
      if (i == 0) push_request(d);
      d.cmd = CMD_LOAD; d.mark_addr = 16'h0000; d.sample = 8'd200;
      if (i == 0) push_request(d);
      d.cmd = ~CMD_LOAD; d.sample = (i[0]) ? 8'hFF : 8'd0;
      push_request(d);
    end
    run_phase(0, 0, 4, 2, 2, 1, 1, 1, 8, 0);             // zero weight
    run_phase(6, 65536, 5, 3, 2, 2, 2, 2, 6, 0);         // full weight
    run_phase(3, 100000, 6, 5, 3, 2, 1, 1, 5, 0);        // weight above one
    run_phase(15, 30000, 3, 2, 1, 1, 1, 1, 3, 0);        // undefined mode
    run_phase(7, 40000, 0, 0, 0, 0, 0, 0, 2, 0);         // zero dimensions
    run_phase(8, 50000, 8191, 2, 255, 1, 7, 7, 4, 0);    // oversize dimensions
    run_phase(8, 50000, 7, 5, 2, 2, 3, 2, 40, 1);        // sparse tiling, long stall

    // random settings; keep sizes small except a few extremes
    while (sent_count < 2000) begin
      case ($urandom_range(0, 15))
        0: run_phase($urandom_range(0, 8), $urandom_range(1, 65536), 4096, 4096,
                     128, 1, 1, 1, 200, 0);
        1: run_phase($urandom_range(0, 8), $urandom_range(1, 65536), 3, 140,
                     1, 128, 1, 1, 200, 0);
        default: begin
          w = $urandom_range(0, 9);
          run_phase(($urandom_range(0, 7) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8),
                    (w == 0) ? 0 : (w == 1) ? 65536 : (w == 2) ? $urandom_range(65537, 131071)
                                 : $urandom_range(1, 65535),
                    $urandom_range(1, 24), $urandom_range(1, 12),
                    $urandom_range(1, 16), $urandom_range(1, 8),
                    $urandom_range(1, 4), $urandom_range(1, 4),
                    $urandom_range(20, 400), $urandom_range(0, 5) == 0);
        end
      endcase
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
